[src/pimc_pkg.sv]
package pimc_pkg;

    localparam int DEF_MAX_WAITERS = 16;

    typedef enum logic [1:0] {
        KIND_LOCK    = 2'd0,
        KIND_TRYLOCK = 2'd1,
        KIND_UNLOCK  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_ACQUIRED  = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_BUSY      = 3'd2,
        ST_ALREADY   = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_RELEASED  = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_TAKE,
        T_FIN
    } top_state_t;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_SCAN,
        Q_PREP,
        Q_SHIFT
    } q_state_t;

    typedef struct packed {
        logic [3:0] id;
        logic [7:0] pri;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   take;
        entry_t entry;
    } q_cmd_t;

    typedef struct packed {
        logic   done;
        entry_t best;
    } q_rsp_t;

    typedef struct packed {
        status_t    status;
        logic       boost_valid;
        logic [3:0] boosted_task;
        logic [7:0] boosted_priority;
        logic       restore_valid;
        logic [7:0] restore_priority;
        logic       woken_valid;
        logic [3:0] woken_task;
    } result_t;

endpackage

[src/pimc_queue.sv]
module pimc_queue #(
    parameter int MAX_WAITERS = pimc_pkg::DEF_MAX_WAITERS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pimc_pkg::q_cmd_t                   cmd,
    output pimc_pkg::q_rsp_t                   rsp,
    output logic [$clog2(MAX_WAITERS + 1)-1:0] count
);
    import pimc_pkg::*;

    localparam int AW = $clog2(MAX_WAITERS);
    localparam int CW = $clog2(MAX_WAITERS + 1);

    entry_t mem [MAX_WAITERS];
    entry_t rd_data_reg;

    q_state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    entry_t        best_reg, best_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_inc2;
    logic [CW-1:0] best_inc;
    logic          scan_last;
    logic          prep_last;
    logic          shift_last;

    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign idx_inc2   = CW'(idx_reg) + CW'(2);
    assign best_inc   = CW'(best_idx_reg) + CW'(1);
    assign scan_last  = (idx_inc == count_reg);
    assign prep_last  = (best_inc == count_reg);
    assign shift_last = (idx_inc2 == count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (cmd.take)
                    state_next = Q_SCAN;
            end
            Q_SCAN:
            begin
                if (scan_last)
                    state_next = Q_PREP;
            end
            Q_PREP:
            begin
                state_next = prep_last ? Q_IDLE : Q_SHIFT;
            end
            Q_SHIFT:
            begin
                if (shift_last)
                    state_next = Q_IDLE;
            end
            default: state_next = Q_IDLE;
        endcase
    end

    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = cmd.entry;
        rd_addr       = '0;
        count_next    = count_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        rsp.done      = 1'b0;
        rsp.best      = best_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (cmd.push)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                idx_next = '0;
            end
            Q_SCAN:
            begin
                // rd_data_reg holds entry idx_reg
                if (idx_reg == '0 || rd_data_reg.pri > best_reg.pri)
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = idx_reg;
                end
                rd_addr  = idx_inc[AW-1:0];
                idx_next = idx_inc[AW-1:0];
            end
            Q_PREP:
            begin
                rd_addr  = best_inc[AW-1:0];
                idx_next = best_idx_reg;
                if (prep_last)
                begin
                    rsp.done   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            Q_SHIFT:
            begin
                // rd_data_reg holds entry idx_reg + 1
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                rd_addr  = idx_inc2[AW-1:0];
                idx_next = idx_inc[AW-1:0];
                if (shift_last)
                begin
                    rsp.done   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAITERS))
        else $error("waiter count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == Q_SCAN) |-> (count_reg != '0))
        else $error("scan of an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == Q_SHIFT) |-> (idx_inc < count_reg))
        else $error("compaction past the queue tail");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && state_reg == Q_IDLE) |-> (count_reg < CW'(MAX_WAITERS)))
        else $error("push into a full queue");

endmodule

[src/priority_inheritance_mutex_core.sv]
// channel  dir  tdata                                      tuser        tlast
// s_axis   in   task_id, task_priority                     kind         -
// m_axis   out  boost/boosted_task/boosted_priority,       status       -
//               restore/restore_priority, woken/woken_task
//
// lock, trylock, refused or idle-queue unlock: result registered
// unlock with n waiters: paced by the queue memory port
//   (one entry read per cycle for the best-priority scan, then the compaction)
// no request is taken while an unlock works or while a result waits unread
// reset: mutex free, queue empty; queue memory contents are not cleared
module priority_inheritance_mutex_core #(
    parameter int MAX_WAITERS = pimc_pkg::DEF_MAX_WAITERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // task_id, task_priority
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // boost_valid, boosted_task, boosted_priority,
                                   // restore_valid, restore_priority, woken_valid,
                                   // woken_task
    output logic [2:0]  m_tuser    // status
);
    import pimc_pkg::*;

    localparam int CW = $clog2(MAX_WAITERS + 1);

    top_state_t state_reg, state_next;
    logic       held_reg, held_next;
    logic [3:0] owner_reg, owner_next;
    logic [7:0] owner_pri_reg, owner_pri_next;
    logic       boosted_reg, boosted_next;
    logic [7:0] saved_reg, saved_next;
    logic       rv_reg, rv_next;
    logic [7:0] rp_reg, rp_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    q_cmd_t        qcmd;
    q_rsp_t        qrsp;
    logic [CW-1:0] qcount;

    logic       accept;
    logic       out_free;
    kind_t      kind;
    logic [3:0] req_id;
    logic [7:0] req_pri;
    result_t    res;

    assign kind     = kind_t'(s_tuser);
    assign req_id   = s_tdata[3:0];
    assign req_pri  = s_tdata[11:4];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == T_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    pimc_queue #(
        .MAX_WAITERS(MAX_WAITERS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qcmd),
        .rsp   (qrsp),
        .count (qcount)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept && kind == KIND_UNLOCK && held_reg && owner_reg == req_id
                    && qcount != '0)
                    state_next = T_TAKE;
            end
            T_TAKE:
            begin
                if (qrsp.done)
                    state_next = T_FIN;
            end
            T_FIN:
            begin
                if (out_free)
                    state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        held_next      = held_reg;
        owner_next     = owner_reg;
        owner_pri_next = owner_pri_reg;
        boosted_next   = boosted_reg;
        saved_next     = saved_reg;
        rv_next        = rv_reg;
        rp_next        = rp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        res            = '0;
        qcmd.push      = 1'b0;
        qcmd.take      = 1'b0;
        qcmd.entry.id  = req_id;
        qcmd.entry.pri = req_pri;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind) inside
                        KIND_LOCK, KIND_TRYLOCK:
                        begin
                            out_valid_next = 1'b1;
                            if (!held_reg)
                            begin
                                held_next      = 1'b1;
                                owner_next     = req_id;
                                owner_pri_next = req_pri;
                                boosted_next   = 1'b0;
                                res.status     = ST_ACQUIRED;
                            end
                            else if (kind == KIND_TRYLOCK)
                                res.status = ST_BUSY;
                            else if (owner_reg == req_id)
                                res.status = ST_ALREADY;
                            else if (qcount >= CW'(MAX_WAITERS))
                                res.status = ST_FULL;
                            else
                            begin
                                qcmd.push  = 1'b1;
                                res.status = ST_BLOCKED;
                                if (req_pri > owner_pri_reg)
                                begin
                                    if (!boosted_reg)
                                    begin
                                        saved_next   = owner_pri_reg;
                                        boosted_next = 1'b1;
                                    end
                                    owner_pri_next       = req_pri;
                                    res.boost_valid      = 1'b1;
                                    res.boosted_task     = owner_reg;
                                    res.boosted_priority = req_pri;
                                end
                            end
                            out_next = res;
                        end
                        KIND_UNLOCK:
                        begin
                            if (!held_reg || owner_reg != req_id)
                            begin
                                res.status     = ST_NOT_OWNER;
                                out_valid_next = 1'b1;
                                out_next       = res;
                            end
                            else
                            begin
                                res.status = ST_RELEASED;
                                if (boosted_reg)
                                begin
                                    res.restore_valid    = 1'b1;
                                    res.restore_priority = saved_reg;
                                    boosted_next         = 1'b0;
                                    saved_next           = '0;
                                end
                                if (qcount != '0)
                                begin
                                    qcmd.take = 1'b1;
                                    rv_next   = res.restore_valid;
                                    rp_next   = res.restore_priority;
                                end
                                else
                                begin
                                    held_next      = 1'b0;
                                    owner_next     = '0;
                                    owner_pri_next = '0;
                                    out_valid_next = 1'b1;
                                    out_next       = res;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            T_TAKE:
            begin
                if (qrsp.done)
                begin
                    owner_next     = qrsp.best.id;
                    owner_pri_next = qrsp.best.pri;
                end
            end
            T_FIN:
            begin
                if (out_free)
                begin
                    res.status           = ST_RELEASED;
                    res.restore_valid    = rv_reg;
                    res.restore_priority = rp_reg;
                    res.woken_valid      = 1'b1;
                    res.woken_task       = owner_reg;
                    out_valid_next       = 1'b1;
                    out_next             = res;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {5'd0, out_reg.woken_task, out_reg.woken_valid,
                       out_reg.restore_priority, out_reg.restore_valid,
                       out_reg.boosted_priority, out_reg.boosted_task,
                       out_reg.boost_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            owner_pri_reg <= '0;
            boosted_reg   <= 1'b0;
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            owner_reg     <= owner_next;
            owner_pri_reg <= owner_pri_next;
            boosted_reg   <= boosted_next;
            saved_reg     <= saved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg  <= rv_next;
        rp_reg  <= rp_next;
        out_reg <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> (qcount == '0))
        else $error("waiters queued on a free mutex");

    assert property (@(posedge clk) disable iff (!rst_n)
        qrsp.done |-> (state_reg == T_TAKE))
        else $error("queue handover outside an unlock");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_TAKE) |-> (held_reg && !boosted_reg))
        else $error("handover with mutex free or still boosted");

    assert property (@(posedge clk) disable iff (!rst_n)
        (boosted_reg && state_reg == T_IDLE) |-> (owner_pri_reg > saved_reg))
        else $error("boosted owner not above its saved priority");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import pimc_pkg::*;

    localparam int         N_ITEMS         = 1150;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         HOLD_OFF_CYCLES = 250;
    localparam int         HOLD_OFF_AT     = 300;
    localparam int         TAIL_CYCLES     = 60;
    localparam int         N_DIRECTED      = 22;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic [3:0] id;
        logic [7:0] pri;
        bit         typed;
        status_t    status;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // mirror of the mutex
    logic        mx_held      = 1'b0;
    logic [3:0]  mx_owner     = '0;
    logic [7:0]  mx_owner_pri = '0;
    logic        mx_boosted   = 1'b0;
    logic [7:0]  mx_saved_pri = '0;
    logic [3:0]  wait_ids [DEF_MAX_WAITERS];
    logic [7:0]  wait_pris [DEF_MAX_WAITERS];
    int          mx_n_waiting = 0;

    result_t     mutex_outcomes_due[$];
    int          n_errors     = 0;
    int          n_requests   = 0;
    int          n_ignored    = 0;
    int          n_checked    = 0;
    int          n_full       = 0;
    int          n_boost      = 0;
    int          n_restore    = 0;
    int          n_woken      = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    priority_inheritance_mutex_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic bit mutex_predict(input logic [1:0] kind, input logic [3:0] id,
                                         input logic [7:0] pri, output result_t r);
        int best;
        int i;
        r = '0;
        if (kind == KIND_UNUSED)
            return 1'b0;
        if (kind == KIND_LOCK || kind == KIND_TRYLOCK)
        begin
            if (!mx_held)
            begin
                mx_held      = 1'b1;
                mx_owner     = id;
                mx_owner_pri = pri;
                mx_boosted   = 1'b0;
                r.status     = ST_ACQUIRED;
            end
            else if (kind == KIND_TRYLOCK)
                r.status = ST_BUSY;
            else if (mx_owner == id)
                r.status = ST_ALREADY;
            else if (mx_n_waiting >= DEF_MAX_WAITERS)
                r.status = ST_FULL;
            else
            begin
                wait_ids[mx_n_waiting]  = id;
                wait_pris[mx_n_waiting] = pri;
                mx_n_waiting++;
                r.status = ST_BLOCKED;
                if (pri > mx_owner_pri)
                begin
                    if (!mx_boosted)
                    begin
                        mx_saved_pri = mx_owner_pri;
                        mx_boosted   = 1'b1;
                    end
                    mx_owner_pri       = pri;
                    r.boost_valid      = 1'b1;
                    r.boosted_task     = mx_owner;
                    r.boosted_priority = pri;
                end
            end
        end
        else if (!mx_held || mx_owner != id)
            r.status = ST_NOT_OWNER;
        else
        begin
            r.status = ST_RELEASED;
            if (mx_boosted)
            begin
                r.restore_valid    = 1'b1;
                r.restore_priority = mx_saved_pri;
                mx_boosted         = 1'b0;
                mx_saved_pri       = '0;
            end
            if (mx_n_waiting > 0)
            begin
                best = 0;
                for (i = 1; i < mx_n_waiting; i++)
                    if (wait_pris[i] > wait_pris[best])
                        best = i;
                mx_owner     = wait_ids[best];
                mx_owner_pri = wait_pris[best];
                for (i = best; i + 1 < mx_n_waiting; i++)
                begin
                    wait_ids[i]  = wait_ids[i + 1];
                    wait_pris[i] = wait_pris[i + 1];
                end
                mx_n_waiting--;
                r.woken_valid = 1'b1;
                r.woken_task  = mx_owner;
            end
            else
            begin
                mx_held      = 1'b0;
                mx_owner     = '0;
                mx_owner_pri = '0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [3:0] id,
                                input logic [7:0] pri, input bit typed,
                                input status_t typed_status, input int gap,
                                input bit drain_first);
        result_t pred;
        result_t typed_r;
        bit      has;
        if (gap > 0 || (drain_first && mutex_outcomes_due.size() != 0))
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain_first && mutex_outcomes_due.size() != 0)
                @(posedge clk);
        end
        s_tdata  <= {4'b0000, pri, id};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        has = mutex_predict(kind, id, pri, pred);
        if (!has)
            n_ignored++;
        else
        begin
            n_requests++;
            n_full    += (pred.status == ST_FULL);
            n_boost   += pred.boost_valid;
            n_restore += pred.restore_valid;
            n_woken   += pred.woken_valid;
            typed_r        = '0;
            typed_r.status = typed_status;
            mutex_outcomes_due.push_back(typed ? typed_r : pred);
        end
    endtask

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            n_errors++;
        end
    endtask

    initial
    begin : stimulus
        dir_row_t   dir_rows [N_DIRECTED];
        logic [1:0] kind;
        logic [3:0] id;
        logic [7:0] pri;
        int         n_counted;
        int         phase;
        int         r;
        int         gap;
        bit         drain;
        dir_rows = '{
            '{KIND_UNLOCK,  4'd0,  8'h00, 1'b1, ST_NOT_OWNER},
            '{KIND_TRYLOCK, 4'd3,  8'h10, 1'b1, ST_ACQUIRED},
            '{KIND_TRYLOCK, 4'd3,  8'h10, 1'b1, ST_BUSY},
            '{KIND_LOCK,    4'd3,  8'h10, 1'b1, ST_ALREADY},
            '{KIND_UNUSED,  4'd15, 8'hFF, 1'b0, ST_ACQUIRED},
            '{KIND_LOCK,    4'd5,  8'h10, 1'b0, ST_ACQUIRED},
            '{KIND_LOCK,    4'd7,  8'hFF, 1'b0, ST_ACQUIRED},
            '{KIND_LOCK,    4'd9,  8'h80, 1'b0, ST_ACQUIRED},
            '{KIND_LOCK,    4'd5,  8'h20, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd5,  8'h00, 1'b1, ST_NOT_OWNER},
            '{KIND_UNLOCK,  4'd3,  8'h10, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd7,  8'hFF, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd9,  8'h80, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd5,  8'h20, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd5,  8'h10, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd5,  8'h10, 1'b1, ST_NOT_OWNER},
            '{KIND_LOCK,    4'd0,  8'h00, 1'b1, ST_ACQUIRED},
            '{KIND_LOCK,    4'd15, 8'hFF, 1'b0, ST_ACQUIRED},
            '{KIND_LOCK,    4'd14, 8'hFE, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd0,  8'h00, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd15, 8'hFF, 1'b0, ST_ACQUIRED},
            '{KIND_UNLOCK,  4'd14, 8'hFE, 1'b0, ST_ACQUIRED}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].kind, dir_rows[k].id, dir_rows[k].pri,
                         dir_rows[k].typed, dir_rows[k].status,
                         $urandom_range(0, 19), 1'b0);

        // random part: balanced, lock-heavy and unlock-heavy phases
        n_counted = 0;
        while (n_counted < N_ITEMS)
        begin
            phase = (n_counted / 100) % 3;
            r     = $urandom_range(0, 99);
            id    = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0:       pri = 8'h00;
                1:       pri = 8'hFF;
                2:       pri = 8'h80;
                default: pri = 8'($urandom_range(0, 255));
            endcase
            if (r < 3)
                kind = KIND_UNUSED;
            else if (phase == 1)
                kind = (r < 85) ? KIND_LOCK : (r < 90) ? KIND_TRYLOCK : KIND_UNLOCK;
            else if (phase == 2)
                kind = (r < 20) ? KIND_LOCK : (r < 30) ? KIND_TRYLOCK : KIND_UNLOCK;
            else
                kind = (r < 40) ? KIND_LOCK : (r < 52) ? KIND_TRYLOCK : KIND_UNLOCK;
            if (mx_held && kind == KIND_UNLOCK && $urandom_range(0, 9) < 8)
                id = mx_owner;
            if (mx_held && kind == KIND_LOCK && $urandom_range(0, 9) == 0)
                id = mx_owner;
            gap   = (n_counted >= 400 && n_counted < 520) ? 0 : $urandom_range(0, 19);
            drain = (n_counted == 650);
            send_request(kind, id, pri, 1'b0, ST_ACQUIRED, gap, drain);
            if (kind != KIND_UNUSED)
                n_counted++;
        end
        s_tvalid <= 1'b0;

        while (mutex_outcomes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d requests and %0d ignored kinds, %0d results checked",
                 n_requests, n_ignored, n_checked);
        $display("queue full %0d, boosts %0d, restores %0d, handovers %0d",
                 n_full, n_boost, n_restore, n_woken);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : sink
        int w;
        int n_taken;
        n_taken = 0;
        @(posedge rst_n);
        forever
        begin
            w = (n_taken >= 450 && n_taken < 600) ? 0 : $urandom_range(0, 19);
            if (n_taken == HOLD_OFF_AT)
                w = HOLD_OFF_CYCLES;
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            n_taken++;
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mutex_outcomes_due.size() == 0)
            begin
                $error("result with no request outstanding");
                n_errors++;
            end
            else
            begin
                due = mutex_outcomes_due.pop_front();
                n_checked++;
                check_field("status",           due.status,           m_tuser);
                check_field("boost_valid",      due.boost_valid,      m_tdata[0]);
                check_field("boosted_task",     due.boosted_task,     m_tdata[4:1]);
                check_field("boosted_priority", due.boosted_priority, m_tdata[12:5]);
                check_field("restore_valid",    due.restore_valid,    m_tdata[13]);
                check_field("restore_priority", due.restore_priority, m_tdata[21:14]);
                check_field("woken_valid",      due.woken_valid,      m_tdata[22]);
                check_field("woken_task",       due.woken_task,       m_tdata[26:23]);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
